// ===== sv/prft_pkg.sv =====
package prft_pkg;

   localparam int ENTRY_COUNT_DEF    = 64;
   localparam int NAME_LEN_DEF       = 14;
   localparam int MAX_COMPONENTS_DEF = 16;

   localparam int LEN_W   = 4;
   localparam int COUNT_W = 5;

   localparam logic [7:0] ROOT_INDEX = 8'd255;
   localparam logic [7:0] SLASH_CHAR = 8'h2F;
   localparam logic [7:0] DOT_CHAR   = 8'h2E;
   localparam logic [7:0] FOLDER_CODE_RESET = 8'd255;

   localparam logic [2:0] KIND_NAME  = 3'd0;
   localparam logic [2:0] KIND_META  = 3'd1;
   localparam logic [2:0] KIND_START = 3'd2;
   localparam logic [2:0] KIND_CHAR  = 3'd3;
   localparam logic [2:0] KIND_END   = 3'd4;

   localparam logic [1:0] STATUS_FOLDER   = 2'd0;
   localparam logic [1:0] STATUS_FILE     = 2'd1;
   localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

   typedef struct packed {
      logic       we_name;
      logic       we_meta;
      logic [7:0] idx;
      logic [3:0] pos;
      logic [7:0] data;
      logic [7:0] parent;
      logic [7:0] kind_byte;
   } tbl_wr_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] parent;
      logic [7:0] kind_byte;
   } tbl_rd_type;

endpackage

// ===== sv/prft_table.sv =====
module prft_table #(
   parameter int ENTRY_COUNT = prft_pkg::ENTRY_COUNT_DEF,
   parameter int NAME_LEN    = prft_pkg::NAME_LEN_DEF,
   localparam int EIDX_W     = $clog2(ENTRY_COUNT)
) (
   input  logic                          clock,
   input  prft_pkg::tbl_wr_type          wr,
   input  logic [EIDX_W-1:0]             rd_addr,
   input  logic [7:0]                    comp_buf [NAME_LEN],
   input  logic [prft_pkg::LEN_W-1:0]    comp_len,
   input  logic [7:0]                    dir,
   output prft_pkg::tbl_rd_type          rd
);

   logic [NAME_LEN*8-1:0] name_mem [ENTRY_COUNT];
   logic [7:0]            par_mem  [ENTRY_COUNT];
   logic [7:0]            typ_mem  [ENTRY_COUNT];

   logic [NAME_LEN*8-1:0] name_rd_ff;
   logic [7:0]            par_rd_ff;
   logic [7:0]            typ_rd_ff;
   logic [EIDX_W-1:0]     waddr;
   logic [NAME_LEN-1:0]   pos_ok;

   assign waddr = wr.idx[EIDX_W-1:0];

   always_ff @(posedge clock) begin
      if (wr.we_name) begin
         name_mem[waddr][{wr.pos, 3'b000} +: 8] <= wr.data;
      end
      if (wr.we_meta) begin
         par_mem[waddr] <= wr.parent;
         typ_mem[waddr] <= wr.kind_byte;
      end
      name_rd_ff <= name_mem[rd_addr];
      par_rd_ff  <= par_mem[rd_addr];
      typ_rd_ff  <= typ_mem[rd_addr];
   end

   // A stored name matches when its first comp_len bytes equal the component and the
   // byte after them, if there is one, ends the name.
   always_comb begin
      for (int p = 0; p < NAME_LEN; p++) begin
         if (prft_pkg::LEN_W'(p) < comp_len) begin
            pos_ok[p] = (name_rd_ff[p*8 +: 8] == comp_buf[p]);
         end else if (prft_pkg::LEN_W'(p) == comp_len) begin
            pos_ok[p] = (name_rd_ff[p*8 +: 8] == 8'd0);
         end else begin
            pos_ok[p] = 1'b1;
         end
      end
   end

   assign rd.hit       = (&pos_ok) && (par_rd_ff == dir);
   assign rd.parent    = par_rd_ff;
   assign rd.kind_byte = typ_rd_ff;

endmodule

// ===== sv/path_resolver_flat_dir_table_core.sv =====
// Channel | Direction | Handshake              | Content
// req     | in        | req_tvalid/req_tready  | table writes, path start, characters, end
// rsp     | out       | rsp_tvalid/rsp_tready  | status and entry reached, one per path end
// csr     | in        | csr_valid/csr_ready    | folder type code, always ready
// Table writes, start requests and ordinary characters are handled while idle.
// A separating slash, or an end with a component pending, enters a decode state;
// unless decode settles it, a scan of the table follows at one entry per cycle
// through a single registered read port, or a parent step. An end then loads the
// result register once rsp is free. Reset is synchronous, returns to the root path.
// The block takes no item outside idle: decode, scan, parent step or result wait.
module path_resolver_flat_dir_table_core #(
   parameter int ENTRY_COUNT    = prft_pkg::ENTRY_COUNT_DEF,
   parameter int NAME_LEN       = prft_pkg::NAME_LEN_DEF,
   parameter int MAX_COMPONENTS = prft_pkg::MAX_COMPONENTS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // entry_index[5:0], name_pos[9:6], data_byte[17:10], parent_byte[25:18],
   // type_byte[33:26], start_dir[41:34], zero fill above.
   input  logic [47:0] req_tdata,
   // req_type[2:0].
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // resolved_entry[7:0].
   output logic [7:0]  rsp_tdata,
   // status[1:0].
   output logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int EIDX_W = $clog2(ENTRY_COUNT);
   localparam logic [EIDX_W-1:0] LAST_ENTRY = EIDX_W'(ENTRY_COUNT - 1);
   localparam int DOT2_POS = (NAME_LEN > 1) ? 1 : 0;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EVAL   = 3'd1;
   localparam logic [2:0] S_SEARCH = 3'd2;
   localparam logic [2:0] S_UP     = 3'd3;
   localparam logic [2:0] S_EMIT   = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic        end_ff, end_in;
   logic [7:0]  latch_ff, latch_in;
   logic [7:0]  dir_ff, dir_in;
   logic        folder_ff, folder_in;
   logic        ok_ff, ok_in;
   logic [7:0]  comp_buf_ff [NAME_LEN];
   logic [7:0]  comp_buf_in [NAME_LEN];
   logic [prft_pkg::LEN_W-1:0]   comp_len_ff, comp_len_in;
   logic        ovf_ff, ovf_in;
   logic [prft_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [EIDX_W-1:0] scan_ff, scan_in;
   logic        issue_ff, issue_in;
   logic        cmp_vld_ff, cmp_vld_in;
   logic [EIDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_entry_ff, rsp_entry_in;
   logic [7:0]  code_ff, code_in;

   logic [2:0]  kind;
   logic [7:0]  entry_idx;
   logic [3:0]  name_pos;
   logic [7:0]  data_byte;
   logic [7:0]  start_dir;
   logic        accept;
   logic        idx_ok;
   logic        is_dot;
   logic        is_dotdot;
   logic        finish;
   logic        search_done;
   logic [EIDX_W-1:0] rd_addr;
   prft_pkg::tbl_wr_type wr;
   prft_pkg::tbl_rd_type rd;

   assign kind      = req_tuser;
   assign entry_idx = {2'b00, req_tdata[5:0]};
   assign name_pos  = req_tdata[9:6];
   assign data_byte = req_tdata[17:10];
   assign start_dir = req_tdata[41:34];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign idx_ok     = (9'(entry_idx) < 9'(ENTRY_COUNT));

   assign is_dot    = !ovf_ff && (comp_len_ff == prft_pkg::LEN_W'(1)) &&
                      (comp_buf_ff[0] == prft_pkg::DOT_CHAR);
   assign is_dotdot = !ovf_ff && (comp_len_ff == prft_pkg::LEN_W'(2)) &&
                      (comp_buf_ff[0] == prft_pkg::DOT_CHAR) &&
                      (comp_buf_ff[DOT2_POS] == prft_pkg::DOT_CHAR);

   always_comb begin
      wr.we_name   = accept && (kind == prft_pkg::KIND_NAME) && idx_ok &&
                     (5'(name_pos) < 5'(NAME_LEN));
      wr.we_meta   = accept && (kind == prft_pkg::KIND_META) && idx_ok;
      wr.idx       = entry_idx;
      wr.pos       = name_pos;
      wr.data      = data_byte;
      wr.parent    = req_tdata[25:18];
      wr.kind_byte = req_tdata[33:26];
   end

   assign rd_addr = (state_ff == S_EVAL) ? dir_ff[EIDX_W-1:0] : scan_ff;

   prft_table #(
      .ENTRY_COUNT (ENTRY_COUNT),
      .NAME_LEN    (NAME_LEN)
   ) u_table (
      .clock    (clock),
      .wr       (wr),
      .rd_addr  (rd_addr),
      .comp_buf (comp_buf_ff),
      .comp_len (comp_len_ff),
      .dir      (dir_ff),
      .rd       (rd)
   );

   assign search_done = (state_ff == S_SEARCH) && cmp_vld_ff &&
                        (rd.hit || (cmp_idx_ff == LAST_ENTRY));

   always_comb begin
      state_in      = state_ff;
      end_in        = end_ff;
      latch_in      = latch_ff;
      dir_in        = dir_ff;
      folder_in     = folder_ff;
      ok_in         = ok_ff;
      comp_buf_in   = comp_buf_ff;
      comp_len_in   = comp_len_ff;
      ovf_in        = ovf_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      issue_in      = issue_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = scan_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      code_in       = (csr_valid && csr_ready) ? csr_data : code_ff;
      finish        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (kind)
                  prft_pkg::KIND_START: begin
                     latch_in    = start_dir;
                     dir_in      = start_dir;
                     folder_in   = 1'b1;
                     ok_in       = 1'b1;
                     comp_len_in = '0;
                     ovf_in      = 1'b0;
                     count_in    = '0;
                  end
                  prft_pkg::KIND_CHAR: begin
                     if (data_byte != 8'd0) begin
                        if ((data_byte == prft_pkg::SLASH_CHAR) &&
                            (6'(count_ff) + 6'd1 < 6'(MAX_COMPONENTS))) begin
                           end_in   = 1'b0;
                           state_in = S_EVAL;
                        end else if (5'(comp_len_ff) < 5'(NAME_LEN)) begin
                           for (int p = 0; p < NAME_LEN; p++) begin
                              if (comp_len_ff == prft_pkg::LEN_W'(p)) begin
                                 comp_buf_in[p] = data_byte;
                              end
                           end
                           comp_len_in = comp_len_ff + prft_pkg::LEN_W'(1);
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end
                  end
                  prft_pkg::KIND_END: begin
                     end_in = 1'b1;
                     if ((comp_len_ff != '0) || ovf_ff) begin
                        state_in = S_EVAL;
                     end else begin
                        state_in = S_EMIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_EVAL: begin
            if (!ok_ff) begin
               finish = 1'b1;
            end else if (is_dot) begin
               dir_in = latch_ff;
               finish = 1'b1;
            end else if (is_dotdot) begin
               if (9'(dir_ff) < 9'(ENTRY_COUNT)) begin
                  state_in = S_UP;
               end else begin
                  finish = 1'b1;
               end
            end else if (ovf_ff) begin
               ok_in  = 1'b0;
               finish = 1'b1;
            end else begin
               scan_in  = '0;
               issue_in = 1'b1;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (issue_ff) begin
               if (scan_ff == LAST_ENTRY) begin
                  issue_in = 1'b0;
               end else begin
                  scan_in = scan_ff + EIDX_W'(1);
               end
            end
            cmp_vld_in = issue_ff && !search_done;
            if (search_done) begin
               issue_in = 1'b0;
               finish   = 1'b1;
               if (rd.hit) begin
                  dir_in    = 8'(cmp_idx_ff);
                  folder_in = (rd.kind_byte == code_ff);
               end else begin
                  ok_in = 1'b0;
               end
            end
         end
         S_UP: begin
            dir_in = rd.parent;
            finish = 1'b1;
         end
         S_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_entry_in  = dir_ff;
               if (!ok_ff) begin
                  rsp_status_in = prft_pkg::STATUS_NOTFOUND;
               end else if (folder_ff) begin
                  rsp_status_in = prft_pkg::STATUS_FOLDER;
               end else begin
                  rsp_status_in = prft_pkg::STATUS_FILE;
               end
               dir_in      = latch_ff;
               folder_in   = 1'b1;
               ok_in       = 1'b1;
               comp_len_in = '0;
               ovf_in      = 1'b0;
               count_in    = '0;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         if (end_ff) begin
            state_in = S_EMIT;
         end else begin
            comp_len_in = '0;
            ovf_in      = 1'b0;
            count_in    = count_ff + prft_pkg::COUNT_W'(1);
            state_in    = S_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         end_ff        <= 1'b0;
         latch_ff      <= prft_pkg::ROOT_INDEX;
         dir_ff        <= prft_pkg::ROOT_INDEX;
         folder_ff     <= 1'b1;
         ok_ff         <= 1'b1;
         comp_len_ff   <= '0;
         ovf_ff        <= 1'b0;
         count_ff      <= '0;
         issue_ff      <= 1'b0;
         cmp_vld_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         code_ff       <= prft_pkg::FOLDER_CODE_RESET;
      end else begin
         state_ff      <= state_in;
         end_ff        <= end_in;
         latch_ff      <= latch_in;
         dir_ff        <= dir_in;
         folder_ff     <= folder_in;
         ok_ff         <= ok_in;
         comp_len_ff   <= comp_len_in;
         ovf_ff        <= ovf_in;
         count_ff      <= count_in;
         issue_ff      <= issue_in;
         cmp_vld_ff    <= cmp_vld_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         code_ff       <= code_in;
      end
      comp_buf_ff   <= comp_buf_in;
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_entry_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == S_EMIT))
      else $error("result raised outside the emit state");

   a_cmp_in_search: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> $past(state_ff == S_SEARCH) && (state_ff == S_SEARCH))
      else $error("compare slot valid outside a table scan");

   a_up_after_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP) |-> $past(state_ff == S_EVAL))
      else $error("parent step not preceded by decode");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      5'(comp_len_ff) <= 5'(NAME_LEN))
      else $error("component length beyond the name length");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      6'(count_ff) < 6'(MAX_COMPONENTS))
      else $error("component count beyond the limit");

endmodule
